// ===== src/bvg_pkg.sv =====
// shared types, constants and discharge curve of the battery voltage gauge
package bvg_pkg;

    // field and register widths
    localparam int SAMPLE_W   = 12;
    localparam int DIVR_W     = 12;
    localparam int ALPHA_W    = 9;
    localparam int MV_W       = 13;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int FRAC_W     = 8;
    localparam int SMOOTH_W   = MV_W + FRAC_W;
    localparam int SCALED_W   = SAMPLE_W + DIVR_W + 1 - FRAC_W;

    // shared multiplier and divider widths
    localparam int MUL_A_W  = SMOOTH_W;
    localparam int MUL_B_W  = DIVR_W;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int EMA_W    = SMOOTH_W + ALPHA_W;
    localparam int ACC_W    = EMA_W + 1;
    localparam int QUOT_W   = PCT_W;
    localparam int NUM_W    = SMOOTH_W + PCT_W;
    localparam int REM_W    = NUM_W + 1;
    localparam int DCNT_W   = $clog2(QUOT_W);

    // constants
    localparam int ALPHA_ONE  = 256;
    localparam int ROUND_HALF = 128;
    localparam int PCT_MAX    = 100;

    // reset values of the configuration registers
    localparam logic [DIVR_W-1:0]  DIVIDER_RST  = DIVR_W'(512);
    localparam logic [ALPHA_W-1:0] ALPHA_RST    = ALPHA_W'(56);
    localparam logic [MV_W-1:0]    MIN_MV_RST   = MV_W'(2000);
    localparam logic [MV_W-1:0]    MAX_MV_RST   = MV_W'(5500);
    localparam logic [MV_W-1:0]    HIGH_MV_RST  = MV_W'(4600);
    localparam logic [PCT_W-1:0]   LOW_PCT_RST  = PCT_W'(20);
    localparam logic [PCT_W-1:0]   CRIT_PCT_RST = PCT_W'(10);

    // discharge curve
    localparam int KNOT_COUNT = 10;
    localparam int KNOT_IDX_W = 4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIVIDER  = 3'd0,
        REG_ALPHA    = 3'd1,
        REG_MIN_MV   = 3'd2,
        REG_MAX_MV   = 3'd3,
        REG_HIGH_MV  = 3'd4,
        REG_LOW_PCT  = 3'd5,
        REG_CRIT_PCT = 3'd6
    } cfg_reg_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_UNKNOWN  = 3'd0,
        ST_NO_ADC   = 3'd1,
        ST_OK       = 3'd2,
        ST_LOW      = 3'd3,
        ST_CRITICAL = 3'd4,
        ST_HIGH     = 3'd5
    } gauge_status_t;

    typedef enum logic [1:0] {
        RES_UNKNOWN,
        RES_NO_ADC,
        RES_VALID
    } result_kind_t;

    typedef enum logic [1:0] {
        MUL_SCALE,
        MUL_OLD,
        MUL_NEW,
        MUL_SEG
    } mul_sel_t;

    typedef enum logic [1:0] {
        PCT_TOP,
        PCT_ZERO,
        PCT_KNOT,
        PCT_INTERP
    } pct_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_CHECK,
        S_MUL_OLD,
        S_MUL_NEW,
        S_ACC,
        S_SEARCH,
        S_MUL_SEG,
        S_DIV_INIT,
        S_DIV,
        S_PCT,
        S_OUT
    } fsm_state_t;

    // controller to datapath
    typedef struct packed {
        logic         sample_load;
        logic         mul_en;
        mul_sel_t     mul_sel;
        logic         kind_load;
        result_kind_t kind;
        logic         seed;
        logic         acc_load;
        logic         smooth_load;
        logic         seg_clear;
        logic         seg_inc;
        logic         div_init;
        logic         div_step;
        logic         pct_load;
        pct_sel_t     pct_sel;
        logic         out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sample_zero;
        logic in_window;
        logic have_sample;
        logic knot_hit;
        logic seg_first;
        logic seg_last;
        logic den_zero;
        logic div_last;
    } dp_status_t;

    // knot voltages in mV, highest first
    function automatic logic [MV_W-1:0] knot_mv(input logic [KNOT_IDX_W-1:0] idx);
        logic [MV_W-1:0] mv;
        case (idx)
            4'd0:    mv = MV_W'(4200);
            4'd1:    mv = MV_W'(4100);
            4'd2:    mv = MV_W'(4000);
            4'd3:    mv = MV_W'(3900);
            4'd4:    mv = MV_W'(3800);
            4'd5:    mv = MV_W'(3700);
            4'd6:    mv = MV_W'(3600);
            4'd7:    mv = MV_W'(3500);
            4'd8:    mv = MV_W'(3300);
            4'd9:    mv = MV_W'(3200);
            default: mv = '0;
        endcase
        return mv;
    endfunction

    // knot charge in percent
    function automatic logic [PCT_W-1:0] knot_pct(input logic [KNOT_IDX_W-1:0] idx);
        logic [PCT_W-1:0] pct;
        case (idx)
            4'd0:    pct = PCT_W'(100);
            4'd1:    pct = PCT_W'(90);
            4'd2:    pct = PCT_W'(80);
            4'd3:    pct = PCT_W'(65);
            4'd4:    pct = PCT_W'(50);
            4'd5:    pct = PCT_W'(35);
            4'd6:    pct = PCT_W'(20);
            4'd7:    pct = PCT_W'(10);
            4'd8:    pct = PCT_W'(5);
            4'd9:    pct = PCT_W'(0);
            default: pct = '0;
        endcase
        return pct;
    endfunction

endpackage

// ===== src/bvg_datapath.sv =====
// datapath: configuration registers, shared multiplier, smoothing, curve search and divider
module bvg_datapath
    import bvg_pkg::*;
#(
    parameter int CURVE_POINTS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [SAMPLE_W-1:0]   sample_mv,
    input  dp_cmd_t               cmd,
    output dp_status_t            stat,
    output logic                  present,
    output logic [MV_W-1:0]       voltage_mv,
    output logic [PCT_W-1:0]      percent,
    output logic                  low_flag,
    output logic                  critical_flag,
    output logic [2:0]            status
);

    localparam int POINTS = (CURVE_POINTS < KNOT_COUNT) ? CURVE_POINTS : KNOT_COUNT;
    localparam int SEG_W  = $clog2(CURVE_POINTS);

    // configuration registers
    logic [DIVR_W-1:0]  divider_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [MV_W-1:0]    min_mv_reg;
    logic [MV_W-1:0]    max_mv_reg;
    logic [MV_W-1:0]    high_mv_reg;
    logic [PCT_W-1:0]   low_pct_reg;
    logic [PCT_W-1:0]   crit_pct_reg;

    // working registers
    logic [SAMPLE_W-1:0] sample_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [MV_W-1:0]     scaled_reg;
    logic [SMOOTH_W-1:0] smoothed_reg;
    logic                have_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [SEG_W-1:0]    seg_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-1:0]    dsr_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [DCNT_W-1:0]   dcnt_reg;
    logic [PCT_W-1:0]    pct_reg;
    result_kind_t        kind_reg;

    // output payload registers
    logic                present_reg;
    logic [MV_W-1:0]     voltage_reg;
    logic [PCT_W-1:0]    percent_reg;
    logic                low_reg;
    logic                crit_reg;
    gauge_status_t       status_reg;

    logic [SAMPLE_W+DIVR_W:0] scale_sum;
    logic [SCALED_W-1:0]      scaled_full;
    logic [ALPHA_W-1:0]       alpha_sat;
    logic [ALPHA_W-1:0]       alpha_inv;
    logic [KNOT_IDX_W-1:0]    knot_idx;
    logic [KNOT_IDX_W-1:0]    knot_prev;
    logic [MV_W-1:0]          lo_mv;
    logic [MV_W-1:0]          hi_mv;
    logic [SMOOTH_W-1:0]      lo_q8;
    logic [SMOOTH_W-1:0]      den;
    logic [PCT_W-1:0]         dp;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [ACC_W-1:0]         ema_sum;
    logic                     div_ge;
    logic [PCT_W:0]           pct_sum;
    logic [PCT_W-1:0]         pct_next;
    logic [SMOOTH_W:0]        volt_sum;
    logic                     low_hit;
    logic                     crit_hit;
    gauge_status_t            valid_status;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg  <= DIVIDER_RST;
            alpha_reg    <= ALPHA_RST;
            min_mv_reg   <= MIN_MV_RST;
            max_mv_reg   <= MAX_MV_RST;
            high_mv_reg  <= HIGH_MV_RST;
            low_pct_reg  <= LOW_PCT_RST;
            crit_pct_reg <= CRIT_PCT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DIVIDER:  divider_reg  <= cfg_data[DIVR_W-1:0];
                REG_ALPHA:    alpha_reg    <= cfg_data[ALPHA_W-1:0];
                REG_MIN_MV:   min_mv_reg   <= cfg_data[MV_W-1:0];
                REG_MAX_MV:   max_mv_reg   <= cfg_data[MV_W-1:0];
                REG_HIGH_MV:  high_mv_reg  <= cfg_data[MV_W-1:0];
                REG_LOW_PCT:  low_pct_reg  <= cfg_data[PCT_W-1:0];
                REG_CRIT_PCT: crit_pct_reg <= cfg_data[PCT_W-1:0];
                default:      ;
            endcase
        end
    end

    // scaled reading and window check
    assign scale_sum   = (SAMPLE_W+DIVR_W+1)'(prod_reg[SAMPLE_W+DIVR_W-1:0])
                       + (SAMPLE_W+DIVR_W+1)'(ROUND_HALF);
    assign scaled_full = scale_sum[SAMPLE_W+DIVR_W:FRAC_W];

    // alpha saturates at one
    assign alpha_sat = (alpha_reg > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_reg;
    assign alpha_inv = ALPHA_W'(ALPHA_ONE) - alpha_sat;

    // current curve segment
    assign knot_idx  = KNOT_IDX_W'(seg_reg);
    assign knot_prev = knot_idx - KNOT_IDX_W'(1);
    assign lo_mv     = knot_mv(knot_idx);
    assign hi_mv     = knot_mv(knot_prev);
    assign lo_q8     = {lo_mv, {FRAC_W{1'b0}}};
    assign den       = {hi_mv - lo_mv, {FRAC_W{1'b0}}};
    assign dp        = knot_pct(knot_prev) - knot_pct(knot_idx);

    // operand selection for the shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SCALE:
            begin
                mul_a = MUL_A_W'(sample_reg);
                mul_b = divider_reg;
            end
            MUL_OLD:
            begin
                mul_a = smoothed_reg;
                mul_b = MUL_B_W'(alpha_inv);
            end
            MUL_NEW:
            begin
                mul_a = {scaled_reg, {FRAC_W{1'b0}}};
                mul_b = MUL_B_W'(alpha_sat);
            end
            MUL_SEG:
            begin
                mul_a = smoothed_reg - lo_q8;
                mul_b = MUL_B_W'(dp);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // exponential average sum and divider compare
    assign ema_sum = acc_reg + ACC_W'(prod_reg[EMA_W-1:0]);
    assign div_ge  = rem_reg >= dsr_reg;

    // percent selection
    assign pct_sum = (PCT_W+1)'(knot_pct(knot_idx)) + (PCT_W+1)'(quot_reg);
    always_comb
    begin
        case (cmd.pct_sel)
            PCT_TOP:    pct_next = knot_pct(KNOT_IDX_W'(0));
            PCT_ZERO:   pct_next = '0;
            PCT_KNOT:   pct_next = knot_pct(knot_idx);
            PCT_INTERP: pct_next = (pct_sum > (PCT_W+1)'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                                : pct_sum[PCT_W-1:0];
            default:    pct_next = '0;
        endcase
    end

    // smoothing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg <= '0;
            have_reg     <= 1'b0;
        end
        else if (cmd.seed)
        begin
            smoothed_reg <= {scaled_full[MV_W-1:0], {FRAC_W{1'b0}}};
            have_reg     <= 1'b1;
        end
        else if (cmd.smooth_load)
        begin
            smoothed_reg <= ema_sum[SMOOTH_W+FRAC_W-1:FRAC_W];
        end
    end

    // sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg  <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cmd.seg_clear)
                seg_reg <= '0;
            else if (cmd.seg_inc)
                seg_reg <= seg_reg + SEG_W'(1);
            if (cmd.div_init)
                dcnt_reg <= DCNT_W'(QUOT_W - 1);
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.sample_load)
            sample_reg <= sample_mv;
        if (cmd.mul_en)
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (cmd.seed || cmd.kind_load)
            scaled_reg <= scaled_full[MV_W-1:0];
        if (cmd.acc_load)
            acc_reg <= ACC_W'(prod_reg[EMA_W-1:0]) + ACC_W'(ROUND_HALF);
        if (cmd.kind_load)
            kind_reg <= cmd.kind;
        if (cmd.pct_load)
            pct_reg <= pct_next;
        // restoring divide, one quotient bit per step
        if (cmd.div_init)
        begin
            rem_reg  <= REM_W'(prod_reg[NUM_W-1:0]) + REM_W'(den >> 1);
            dsr_reg  <= REM_W'(den) << (QUOT_W - 1);
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
                rem_reg <= rem_reg - dsr_reg;
            dsr_reg  <= dsr_reg >> 1;
            quot_reg <= {quot_reg[QUOT_W-2:0], div_ge};
        end
    end

    // result fields of a valid reading
    assign volt_sum = (SMOOTH_W+1)'(smoothed_reg) + (SMOOTH_W+1)'(ROUND_HALF);
    assign low_hit  = pct_reg <= low_pct_reg;
    assign crit_hit = pct_reg <= crit_pct_reg;
    always_comb
    begin
        if (smoothed_reg > {high_mv_reg, {FRAC_W{1'b0}}})
            valid_status = ST_HIGH;
        else if (crit_hit)
            valid_status = ST_CRITICAL;
        else if (low_hit)
            valid_status = ST_LOW;
        else
            valid_status = ST_OK;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (kind_reg == RES_VALID)
            begin
                present_reg <= 1'b1;
                voltage_reg <= volt_sum[SMOOTH_W-1:FRAC_W];
                percent_reg <= pct_reg;
                low_reg     <= low_hit;
                crit_reg    <= crit_hit;
                status_reg  <= valid_status;
            end
            else
            begin
                present_reg <= 1'b0;
                voltage_reg <= '0;
                percent_reg <= '0;
                low_reg     <= 1'b0;
                crit_reg    <= 1'b0;
                status_reg  <= (kind_reg == RES_NO_ADC) ? ST_NO_ADC : ST_UNKNOWN;
            end
        end
    end

    // status towards the controller
    assign stat.sample_zero = sample_reg == '0;
    assign stat.in_window   = (scaled_full >= SCALED_W'(min_mv_reg))
                           && (scaled_full <= SCALED_W'(max_mv_reg));
    assign stat.have_sample = have_reg;
    assign stat.knot_hit    = smoothed_reg >= lo_q8;
    assign stat.seg_first   = seg_reg == '0;
    assign stat.seg_last    = seg_reg == SEG_W'(POINTS - 1);
    assign stat.den_zero    = hi_mv == lo_mv;
    assign stat.div_last    = dcnt_reg == '0;

    assign present       = present_reg;
    assign voltage_mv    = voltage_reg;
    assign percent       = percent_reg;
    assign low_flag      = low_reg;
    assign critical_flag = crit_reg;
    assign status        = status_reg;

endmodule

// ===== src/bvg_ctrl.sv =====
// controller: sequences one sample through the datapath and runs both handshakes
module bvg_ctrl
    import bvg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t stat,
    output dp_cmd_t    cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_SCALE;
        cmd.kind    = RES_UNKNOWN;
        cmd.pct_sel = PCT_ZERO;
        in_ready    = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.sample_load = in_valid;
                if (in_valid)
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SCALE;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.kind_load = 1'b1;
                cmd.seg_clear = 1'b1;
                if (stat.sample_zero)
                begin
                    cmd.kind   = RES_NO_ADC;
                    state_next = S_OUT;
                end
                else if (!stat.in_window)
                begin
                    cmd.kind   = RES_UNKNOWN;
                    state_next = S_OUT;
                end
                else if (!stat.have_sample)
                begin
                    cmd.kind   = RES_VALID;
                    cmd.seed   = 1'b1;
                    state_next = S_SEARCH;
                end
                else
                begin
                    cmd.kind   = RES_VALID;
                    state_next = S_MUL_OLD;
                end
            end
            S_MUL_OLD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_OLD;
                state_next  = S_MUL_NEW;
            end
            S_MUL_NEW:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_NEW;
                cmd.acc_load = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC:
            begin
                cmd.smooth_load = 1'b1;
                state_next      = S_SEARCH;
            end
            // one knot compared per cycle, highest first
            S_SEARCH:
            begin
                if (stat.knot_hit && stat.seg_first)
                begin
                    cmd.pct_load = 1'b1;
                    cmd.pct_sel  = PCT_TOP;
                    state_next   = S_OUT;
                end
                else if (stat.knot_hit)
                begin
                    state_next = S_MUL_SEG;
                end
                else if (stat.seg_last)
                begin
                    cmd.pct_load = 1'b1;
                    cmd.pct_sel  = PCT_ZERO;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.seg_inc = 1'b1;
                end
            end
            S_MUL_SEG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SEG;
                state_next  = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                if (stat.den_zero)
                begin
                    cmd.pct_load = 1'b1;
                    cmd.pct_sel  = PCT_KNOT;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_PCT;
            end
            S_PCT:
            begin
                cmd.pct_load = 1'b1;
                cmd.pct_sel  = PCT_INTERP;
                state_next   = S_OUT;
            end
            // hold until the output register is free
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/battery_voltage_gauge_core.sv =====
// top level of the battery voltage gauge: controller, datapath and checks
//
// channel   direction  handshake             payload
// in        request in in_valid / in_ready    sample_mv
// out       result out out_valid / out_ready  present, voltage_mv, percent, low_flag,
//                                             critical_flag, status
// cfg       write in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a zero or out-of-window sample goes from the check straight to the output, with no smoothing or search
// a valid reading uses up to four products on the one shared
// 21x12 multiplier, a curve search of one knot per cycle and a 7-step restoring divide
// one request at a time; a new request is taken while the previous result waits
// a stalled output holds the controller in S_OUT, with the next result in the datapath, until the register frees
// reset clears the smoothing state at once; no clearing pass
module battery_voltage_gauge_core
    import bvg_pkg::*;
#(
    parameter int CURVE_POINTS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SAMPLE_W-1:0]   sample_mv,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  present,
    output logic [MV_W-1:0]       voltage_mv,
    output logic [PCT_W-1:0]      percent,
    output logic                  low_flag,
    output logic                  critical_flag,
    output logic [2:0]            status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    bvg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bvg_datapath #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_mv     (sample_mv),
        .cmd           (cmd),
        .stat          (stat),
        .present       (present),
        .voltage_mv    (voltage_mv),
        .percent       (percent),
        .low_flag      (low_flag),
        .critical_flag (critical_flag),
        .status        (status)
    );

`ifndef SYNTHESIS
    // a present result carries a battery status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && present |-> status != ST_UNKNOWN && status != ST_NO_ADC)
        else $error("present result with no battery status");

    // an absent result has all value fields cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !present |-> voltage_mv == '0 && percent == '0
                                  && !low_flag && !critical_flag)
        else $error("absent result with nonzero fields");

    // percent stays on the curve range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> percent <= PCT_W'(PCT_MAX))
        else $error("percent above full charge");

    // an accepted request moves the controller out of idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while one is in progress");
`endif

endmodule
